[src/sdrq_pkg.sv]
// Shared types and codes for the sorted disk request queue.
// Used by the slot store, the top level and the port checker.
package sdrq_pkg;

    // Request kinds carried on s_tuser
    localparam logic REQ_SUBMIT   = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    // Block number and field widths fixed by the item format
    localparam int unsigned BLOCK_W  = 31;
    localparam int unsigned SECTOR_W = 32;
    localparam int unsigned TAG_W    = 16;

    // One stored request
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                cmd;
        logic [TAG_W-1:0]    tag;
    } slot_entry_t;

    // Input item as packed on s_tdata (first field highest)
    typedef struct packed {
        logic [TAG_W-1:0]   buffer_tag;
        logic [BLOCK_W-1:0] block_number;
        logic               write_cmd;
    } in_item_t;

    // Result item as packed on m_tdata (first field highest), padded to 88 bits
    typedef struct packed {
        logic [6:0]          pad;
        logic [5:0]          queue_count;
        logic [TAG_W-1:0]    head_tag;
        logic                head_cmd;
        logic [SECTOR_W-1:0] head_sector;
        logic                head_valid;
        logic [TAG_W-1:0]    retired_tag;
        logic                retired_valid;
        logic                issue_now;
        logic [4:0]          slot_index;
        logic                pool_full;
        logic                accepted;
    } res_item_t;

endpackage

[src/sorted_disk_request_queue.sv]
// Sorted disk request queue: top level with the sequencer and sector compare.
// Depends on sdrq_pkg, sdrq_slot_store and sdrq_order_ring.
//
// Requests are kept in descending sector order behind the head in service.
// One item is handled at a time; s_tready is high only while idle, and the
// result waits in registers on m_tdata until taken. A complete that empties
// the queue goes straight to the result; any other complete steps the head
// pointer, then does order and slot reads to load the new head. A submit
// scans the busy flags one slot per cycle to the first free slot, then walks
// the order ring behind the head (order read, slot read, sector compare for
// each entry) and writes the tail; into an empty queue it needs no walk. A
// submit on a full pool goes straight to the result. Both memories are
// single-port read, single-port write; no clearing pass is needed.
module sorted_disk_request_queue #(
    parameter int unsigned POOL_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // write_cmd, block_number[30:0], buffer_tag[15:0]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // accepted, pool_full, slot_index[4:0], issue_now,
                                   // retired_valid, retired_tag[15:0], head_valid,
                                   // head_sector[31:0], head_cmd, head_tag[15:0],
                                   // queue_count[5:0], zero pad[6:0]
);

    localparam int unsigned SW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_FIND   = 10'b0000000010,
        ST_RD_ORD = 10'b0000000100,
        ST_RD_SEC = 10'b0000001000,
        ST_CMP    = 10'b0000010000,
        ST_TAIL   = 10'b0000100000,
        ST_H_ORD  = 10'b0001000000,
        ST_H_SLOT = 10'b0010000000,
        ST_H_LOAD = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    // Ring pointer step with wrap at the pool depth
    function automatic logic [SW-1:0] ring_inc(input logic [SW-1:0] p);
        logic [SW-1:0] r;
        if (p == SW'(POOL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + SW'(1);
        end
        return r;
    endfunction

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [SW-1:0]         head_ptr_reg, head_ptr_next;
    logic [SW-1:0]         walk_reg, walk_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [SW-1:0]         scan_reg, scan_next;
    logic [SW-1:0]         carry_reg, carry_next;
    logic                  ins_reg, ins_next;
    sdrq_pkg::slot_entry_t new_reg, new_next;
    sdrq_pkg::slot_entry_t head_reg, head_next;
    logic [SW-1:0]         head_slot_reg, head_slot_next;
    logic                  acc_reg, acc_next;
    logic                  full_reg, full_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic                  issue_reg, issue_next;
    logic                  ret_valid_reg, ret_valid_next;
    logic [15:0]           ret_tag_reg, ret_tag_next;

    // Memory controls
    logic                  sw_en, sr_en, set_en, clr_en;
    logic [SW-1:0]         sw_slot, sr_slot;
    sdrq_pkg::slot_entry_t sr_entry;
    logic                  scan_busy;
    logic                  ow_en, or_en;
    logic [SW-1:0]         ow_addr, ow_data, or_addr, or_data;

    sdrq_pkg::in_item_t    in_item;
    sdrq_pkg::res_item_t   res;
    logic [31:0]           slot_wide, count_wide;
    logic                  go_in;

    assign in_item = sdrq_pkg::in_item_t'(s_tdata);
    assign go_in   = s_tvalid && s_tready;

    sdrq_slot_store #(
        .POOL_DEPTH (POOL_DEPTH),
        .SW         (SW)
    ) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (sw_en),
        .wr_slot   (sw_slot),
        .wr_entry  (new_reg),
        .rd_en     (sr_en),
        .rd_slot   (sr_slot),
        .rd_entry  (sr_entry),
        .set_en    (set_en),
        .set_slot  (scan_reg),
        .clr_en    (clr_en),
        .clr_slot  (head_slot_reg),
        .scan_slot (scan_reg),
        .scan_busy (scan_busy)
    );

    sdrq_order_ring #(
        .POOL_DEPTH (POOL_DEPTH),
        .SW         (SW)
    ) u_order (
        .clk     (clk),
        .wr_en   (ow_en),
        .wr_addr (ow_addr),
        .wr_data (ow_data),
        .rd_en   (or_en),
        .rd_addr (or_addr),
        .rd_data (or_data)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_ptr_next  = head_ptr_reg;
        walk_next      = walk_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        carry_next     = carry_reg;
        ins_next       = ins_reg;
        new_next       = new_reg;
        head_next      = head_reg;
        head_slot_next = head_slot_reg;
        acc_next       = acc_reg;
        full_next      = full_reg;
        slot_next      = slot_reg;
        issue_next     = issue_reg;
        ret_valid_next = ret_valid_reg;
        ret_tag_next   = ret_tag_reg;

        sw_en   = 1'b0;
        sw_slot = scan_reg;
        sr_en   = 1'b0;
        sr_slot = or_data;
        set_en  = 1'b0;
        clr_en  = 1'b0;
        ow_en   = 1'b0;
        ow_addr = walk_reg;
        ow_data = carry_reg;
        or_en   = 1'b0;
        or_addr = walk_reg;

        s_tready = 1'b0;
        m_tvalid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (go_in)
                begin
                    acc_next       = 1'b0;
                    full_next      = 1'b0;
                    slot_next      = '0;
                    issue_next     = 1'b0;
                    ret_valid_next = 1'b0;
                    ret_tag_next   = '0;
                    if (s_tuser == sdrq_pkg::REQ_SUBMIT)
                    begin
                        new_next.sector = {in_item.block_number, 1'b0};
                        new_next.cmd    = in_item.write_cmd;
                        new_next.tag    = in_item.buffer_tag;
                        if (count_reg == CW'(POOL_DEPTH))
                        begin
                            full_next  = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            scan_next  = '0;
                            state_next = ST_FIND;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        // retire the head and step the ring
                        ret_valid_next = 1'b1;
                        ret_tag_next   = head_reg.tag;
                        clr_en         = 1'b1;
                        head_ptr_next  = ring_inc(head_ptr_reg);
                        count_next     = count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            head_next      = '0;
                            head_slot_next = '0;
                            state_next     = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_H_ORD;
                        end
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end

            // scan busy flags for the lowest free slot
            ST_FIND:
            begin
                if (!scan_busy)
                begin
                    sw_en      = 1'b1;
                    set_en     = 1'b1;
                    acc_next   = 1'b1;
                    slot_next  = scan_reg;
                    carry_next = scan_reg;
                    if (count_reg == '0)
                    begin
                        ow_en          = 1'b1;
                        ow_addr        = head_ptr_reg;
                        ow_data        = scan_reg;
                        head_next      = new_reg;
                        head_slot_next = scan_reg;
                        issue_next     = 1'b1;
                        count_next     = count_reg + CW'(1);
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        ins_next  = 1'b0;
                        idx_next  = CW'(1);
                        walk_next = ring_inc(head_ptr_reg);
                        if (count_reg == CW'(1))
                        begin
                            state_next = ST_TAIL;
                        end
                        else
                        begin
                            state_next = ST_RD_ORD;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end

            ST_RD_ORD:
            begin
                or_en      = 1'b1;
                state_next = ST_RD_SEC;
            end

            ST_RD_SEC:
            begin
                sr_en      = 1'b1;
                state_next = ST_CMP;
            end

            // shared compare; once inserted, the walk carries entries up by one
            ST_CMP:
            begin
                if (ins_reg || (new_reg.sector > sr_entry.sector))
                begin
                    ow_en      = 1'b1;
                    carry_next = or_data;
                    ins_next   = 1'b1;
                end
                idx_next  = idx_reg + CW'(1);
                walk_next = ring_inc(walk_reg);
                if ((idx_reg + CW'(1)) == count_reg)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    state_next = ST_RD_ORD;
                end
            end

            ST_TAIL:
            begin
                ow_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = ST_OUT;
            end

            // load the new head after a complete
            ST_H_ORD:
            begin
                or_en      = 1'b1;
                or_addr    = head_ptr_reg;
                state_next = ST_H_SLOT;
            end

            ST_H_SLOT:
            begin
                sr_en          = 1'b1;
                head_slot_next = or_data;
                state_next     = ST_H_LOAD;
            end

            ST_H_LOAD:
            begin
                head_next  = sr_entry;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_ptr_reg  <= '0;
            head_reg      <= '0;
            head_slot_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_ptr_reg  <= head_ptr_next;
            head_reg      <= head_next;
            head_slot_reg <= head_slot_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        idx_reg       <= idx_next;
        scan_reg      <= scan_next;
        carry_reg     <= carry_next;
        ins_reg       <= ins_next;
        new_reg       <= new_next;
        acc_reg       <= acc_next;
        full_reg      <= full_next;
        slot_reg      <= slot_next;
        issue_reg     <= issue_next;
        ret_valid_reg <= ret_valid_next;
        ret_tag_reg   <= ret_tag_next;
    end

    // Result packing
    assign slot_wide  = 32'(slot_reg);
    assign count_wide = 32'(count_reg);

    always_comb
    begin
        res               = '0;
        res.accepted      = acc_reg;
        res.pool_full     = full_reg;
        res.slot_index    = slot_wide[4:0];
        res.issue_now     = issue_reg;
        res.retired_valid = ret_valid_reg;
        res.retired_tag   = ret_tag_reg;
        res.head_valid    = (count_reg != '0);
        res.head_sector   = head_reg.sector;
        res.head_cmd      = head_reg.cmd;
        res.head_tag      = head_reg.tag;
        res.queue_count   = count_wide[5:0];
    end

    assign m_tdata = res;

endmodule

[src/sdrq_slot_store.sv]
// Slot store: per-slot request memory plus the busy flags of the pool.
// Depends on sdrq_pkg for the entry type.
module sdrq_slot_store #(
    parameter int unsigned POOL_DEPTH = 32,
    parameter int unsigned SW         = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [SW-1:0]             wr_slot,
    input  sdrq_pkg::slot_entry_t     wr_entry,
    input  logic                      rd_en,
    input  logic [SW-1:0]             rd_slot,
    output sdrq_pkg::slot_entry_t     rd_entry,
    input  logic                      set_en,
    input  logic [SW-1:0]             set_slot,
    input  logic                      clr_en,
    input  logic [SW-1:0]             clr_slot,
    input  logic [SW-1:0]             scan_slot,
    output logic                      scan_busy
);

    sdrq_pkg::slot_entry_t mem [POOL_DEPTH];
    sdrq_pkg::slot_entry_t rd_entry_reg;
    logic [POOL_DEPTH-1:0] busy_reg;

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_slot];
        end
    end

    // Busy flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            if (set_en)
            begin
                busy_reg[set_slot] <= 1'b1;
            end
            if (clr_en)
            begin
                busy_reg[clr_slot] <= 1'b0;
            end
        end
    end

    assign rd_entry  = rd_entry_reg;
    assign scan_busy = busy_reg[scan_slot];

endmodule

[src/sdrq_order_ring.sv]
// Service order ring: slot numbers in order, head at a moving pointer.
// Self-contained memory; no package use.
module sdrq_order_ring #(
    parameter int unsigned POOL_DEPTH = 32,
    parameter int unsigned SW         = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [SW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [SW-1:0] rd_addr,
    output logic [SW-1:0] rd_data
);

    logic [SW-1:0] mem [POOL_DEPTH];
    logic [SW-1:0] rd_data_reg;

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/sdrq_checker.sv]
// Port-level checker for the sorted disk request queue, bound to the top.
// Depends on sdrq_pkg for the result layout.
module sdrq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    sdrq_pkg::res_item_t res;
    assign res = sdrq_pkg::res_item_t'(m_tdata);

    // Offered input items carry known values
    a_known_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown({s_tuser, s_tdata}))
        else $error("unknown input item");

    // One item at a time: never ready while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

    // Accept and reject are exclusive, and neither comes with a retire
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!(res.accepted && res.pool_full)
                      && !(res.retired_valid && (res.accepted || res.pool_full))))
        else $error("conflicting result flags");

    // Issue only on an accepted submit, which then is the head
    a_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.issue_now) |-> (res.accepted && res.head_valid))
        else $error("issue without accepted head");

endmodule

bind sorted_disk_request_queue sdrq_checker u_sdrq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
